// File: rtl/dfow_pkg.sv
// Shared types, constants and microcode store for the depth-first order walker.
// No dependencies; used by dfow_seq and depth_first_order_walker.
`default_nettype none

package dfow_pkg;

  localparam int MaxNodes = 32;
  localparam int NodeW    = $clog2(MaxNodes);
  localparam int CountW   = NodeW + 1;
  localparam int PcW      = 4;

  typedef logic [PcW-1:0] pc_t;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_RUN   = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [4:0] src_node;
    logic [4:0] dst_node;
  } in_item_t;

  typedef struct packed {
    logic [4:0] node_index;
    logic       last;
    logic       empty_res;
  } out_item_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_ACCEPT,
    A_CLEAR,
    A_ADD,
    A_INIT,
    A_ROOT,
    A_LOAD,
    A_DESCEND,
    A_NEXT,
    A_FINISH,
    A_EMPTY
  } act_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_VALID,
    C_MODE_RUN,
    C_MODE_ADD,
    C_MODE_NOP,
    C_N_ZERO,
    C_ROOT_DONE,
    C_ROOT_VIS,
    C_STK_EMPTY
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    pc_t   tgt;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic mode_run;
    logic mode_add;
    logic mode_nop;
    logic n_zero;
    logic root_done;
    logic root_vis;
    logic stk_empty;
    logic stall;
  } seq_status_t;

  localparam pc_t PcIdle     = 4'd0;
  localparam pc_t PcClear    = 4'd4;
  localparam pc_t PcAdd      = 4'd5;
  localparam pc_t PcRun      = 4'd6;
  localparam pc_t PcRootTest = 4'd7;
  localparam pc_t PcLoad     = 4'd10;
  localparam pc_t PcNextRoot = 4'd12;
  localparam pc_t PcFinish   = 4'd13;
  localparam pc_t PcEmpty    = 4'd14;

  function automatic ucode_t rom_word(input pc_t pc);
    ucode_t w;
    w = '{act: A_NONE, cond: C_ALWAYS, tgt: PcIdle};
    unique case (pc)
      4'd0:    w = '{act: A_ACCEPT,  cond: C_NO_VALID,  tgt: PcIdle};
      4'd1:    w = '{act: A_NONE,    cond: C_MODE_RUN,  tgt: PcRun};
      4'd2:    w = '{act: A_NONE,    cond: C_MODE_ADD,  tgt: PcAdd};
      4'd3:    w = '{act: A_NONE,    cond: C_MODE_NOP,  tgt: PcIdle};
      4'd4:    w = '{act: A_CLEAR,   cond: C_ALWAYS,    tgt: PcIdle};
      4'd5:    w = '{act: A_ADD,     cond: C_ALWAYS,    tgt: PcIdle};
      4'd6:    w = '{act: A_INIT,    cond: C_N_ZERO,    tgt: PcEmpty};
      4'd7:    w = '{act: A_NONE,    cond: C_ROOT_DONE, tgt: PcFinish};
      4'd8:    w = '{act: A_NONE,    cond: C_ROOT_VIS,  tgt: PcNextRoot};
      4'd9:    w = '{act: A_ROOT,    cond: C_NEVER,     tgt: PcIdle};
      4'd10:   w = '{act: A_LOAD,    cond: C_STK_EMPTY, tgt: PcNextRoot};
      4'd11:   w = '{act: A_DESCEND, cond: C_ALWAYS,    tgt: PcLoad};
      4'd12:   w = '{act: A_NEXT,    cond: C_ALWAYS,    tgt: PcRootTest};
      4'd13:   w = '{act: A_FINISH,  cond: C_ALWAYS,    tgt: PcIdle};
      4'd14:   w = '{act: A_EMPTY,   cond: C_ALWAYS,    tgt: PcIdle};
      default: w = '{act: A_NONE,    cond: C_ALWAYS,    tgt: PcIdle};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/dfow_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
// Depends on dfow_pkg.
`default_nettype none

module dfow_seq (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dfow_pkg::seq_status_t status_i,
  output dfow_pkg::ucode_t          word_o
);

  dfow_pkg::pc_t pc_q, pc_d;
  logic          taken;

  assign word_o = dfow_pkg::rom_word(pc_q);

  always_comb begin
    unique case (word_o.cond)
      dfow_pkg::C_NEVER:     taken = 1'b0;
      dfow_pkg::C_ALWAYS:    taken = 1'b1;
      dfow_pkg::C_NO_VALID:  taken = !status_i.in_valid;
      dfow_pkg::C_MODE_RUN:  taken = status_i.mode_run;
      dfow_pkg::C_MODE_ADD:  taken = status_i.mode_add;
      dfow_pkg::C_MODE_NOP:  taken = status_i.mode_nop;
      dfow_pkg::C_N_ZERO:    taken = status_i.n_zero;
      dfow_pkg::C_ROOT_DONE: taken = status_i.root_done;
      dfow_pkg::C_ROOT_VIS:  taken = status_i.root_vis;
      dfow_pkg::C_STK_EMPTY: taken = status_i.stk_empty;
      default:               taken = 1'b1;
    endcase
  end

  always_comb begin
    priority if (status_i.stall) begin
      pc_d = pc_q;
    end else if (taken) begin
      pc_d = word_o.tgt;
    end else begin
      pc_d = pc_q + dfow_pkg::pc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= dfow_pkg::PcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/depth_first_order_walker.sv
// Depth-first order walker: adjacency bit matrix, visited marks, path stack.
// Depends on dfow_pkg and dfow_seq.
// Clear and edge items pass the mode tests, then one action step, before the next ready.
// A walk over n nodes pushes and pops each node once through the two-step
// load/descend loop and tests each root once; an empty walk gives only the empty result.
// One item is in work at a time; a waiting result holds the sequencer.
// Reset clears the adjacency matrix, visited marks, stack depth and node count.
`default_nettype none

module depth_first_order_walker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire dfow_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output dfow_pkg::out_item_t      out_item_o,
  input  wire logic                cfg_we_i,
  input  wire logic [5:0]          cfg_data_i
);

  localparam int N  = dfow_pkg::MaxNodes;
  localparam int NW = dfow_pkg::NodeW;
  localparam int CW = dfow_pkg::CountW;

  function automatic logic [NW-1:0] lowest_bit(input logic [N-1:0] bits);
    logic [NW-1:0] idx;
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = NW'(i);
      end
    end
    return idx;
  endfunction

  dfow_pkg::ucode_t      word;
  dfow_pkg::seq_status_t status;

  logic [5:0]    nc_q;
  dfow_pkg::in_item_t item_q;
  logic [N-1:0]  adj_q [N];
  logic [N-1:0]  visited_q;
  logic [N-1:0]  part_q;
  logic [N-1:0]  row_q;
  logic [NW-1:0] stk_q [N];
  logic [CW-1:0] depth_q;
  logic [CW-1:0] root_q;
  logic [CW-1:0] n_q;
  logic [NW-1:0] pend_q;
  logic          pend_v_q;
  logic          out_valid_q;
  dfow_pkg::out_item_t out_q;

  logic          slot_free;
  logic          emit_act;
  logic          run;
  logic [CW-1:0] depth_m1;
  logic [N-1:0]  cand;
  logic          can_descend;
  logic [NW-1:0] w_idx;
  logic [CW-1:0] n_eff;
  logic [N-1:0]  part_new;

  dfow_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .word_o   (word)
  );

  assign slot_free = !out_valid_q || out_ready_i;
  assign emit_act  = (word.act == dfow_pkg::A_ROOT) || (word.act == dfow_pkg::A_DESCEND) ||
                     (word.act == dfow_pkg::A_FINISH) || (word.act == dfow_pkg::A_EMPTY);
  assign run       = !(emit_act && !slot_free);

  assign depth_m1    = depth_q - CW'(1);
  assign cand        = row_q & ~visited_q & part_q;
  assign can_descend = (cand != '0) && (depth_q < CW'(N));
  assign w_idx       = lowest_bit(cand);

  assign n_eff = (nc_q > 6'(N)) ? CW'(N) : CW'(nc_q);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      part_new[i] = (CW'(i) < n_eff);
    end
  end

  always_comb begin
    status.in_valid  = in_valid_i;
    status.mode_run  = (item_q.mode == dfow_pkg::MODE_RUN);
    status.mode_add  = (item_q.mode == dfow_pkg::MODE_ADD);
    status.mode_nop  = (item_q.mode == dfow_pkg::MODE_NOP);
    status.n_zero    = (n_eff == '0);
    status.root_done = (root_q == n_q);
    status.root_vis  = visited_q[root_q[NW-1:0]];
    status.stk_empty = (depth_q == '0);
    status.stall     = !run;
  end

  assign in_ready_o  = (word.act == dfow_pkg::A_ACCEPT);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q <= '0;
    end else if (cfg_we_i) begin
      nc_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        adj_q[i] <= '0;
      end
    end else if (word.act == dfow_pkg::A_CLEAR) begin
      for (int i = 0; i < N; i++) begin
        adj_q[i] <= '0;
      end
    end else if (word.act == dfow_pkg::A_ADD) begin
      adj_q[item_q.src_node][item_q.dst_node] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
    if (word.act == dfow_pkg::A_LOAD) begin
      row_q <= adj_q[stk_q[depth_m1[NW-1:0]]];
    end
    if (run && (word.act == dfow_pkg::A_ROOT)) begin
      stk_q[0] <= root_q[NW-1:0];
    end else if (run && (word.act == dfow_pkg::A_DESCEND) && can_descend) begin
      stk_q[depth_q[NW-1:0]] <= w_idx;
    end
    if (run && (word.act == dfow_pkg::A_ROOT)) begin
      pend_q <= root_q[NW-1:0];
    end else if (run && (word.act == dfow_pkg::A_DESCEND) && can_descend) begin
      pend_q <= w_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
      part_q    <= '0;
      depth_q   <= '0;
      root_q    <= '0;
      n_q       <= '0;
      pend_v_q  <= 1'b0;
    end else if (run) begin
      unique case (word.act)
        dfow_pkg::A_INIT: begin
          visited_q <= '0;
          part_q    <= part_new;
          depth_q   <= '0;
          root_q    <= '0;
          n_q       <= n_eff;
          pend_v_q  <= 1'b0;
        end
        dfow_pkg::A_ROOT: begin
          visited_q[root_q[NW-1:0]] <= 1'b1;
          depth_q  <= CW'(1);
          pend_v_q <= 1'b1;
        end
        dfow_pkg::A_DESCEND: begin
          if (can_descend) begin
            visited_q[w_idx] <= 1'b1;
            depth_q <= depth_q + CW'(1);
          end else begin
            depth_q <= depth_m1;
          end
        end
        dfow_pkg::A_NEXT: begin
          root_q <= root_q + CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!run) begin
      out_valid_q <= out_valid_q;
    end else if (((word.act == dfow_pkg::A_ROOT) && pend_v_q) ||
                 ((word.act == dfow_pkg::A_DESCEND) && can_descend) ||
                 (word.act == dfow_pkg::A_FINISH) || (word.act == dfow_pkg::A_EMPTY)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run) begin
      unique case (word.act)
        dfow_pkg::A_ROOT: begin
          if (pend_v_q) begin
            out_q <= '{node_index: pend_q, last: 1'b0, empty_res: 1'b0};
          end
        end
        dfow_pkg::A_DESCEND: begin
          if (can_descend) begin
            out_q <= '{node_index: pend_q, last: 1'b0, empty_res: 1'b0};
          end
        end
        dfow_pkg::A_FINISH: out_q <= '{node_index: pend_q, last: 1'b1, empty_res: 1'b0};
        dfow_pkg::A_EMPTY:  out_q <= '{node_index: '0, last: 1'b1, empty_res: 1'b1};
        default: begin
        end
      endcase
    end
  end

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= CW'(N))
    else $error("stack depth beyond node limit");

  a_visited_in_part: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (visited_q & ~part_q) == '0)
    else $error("node outside the walk marked visited");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.empty_res |-> out_item_o.last)
    else $error("empty result not flagged last");

  a_finish_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word.act == dfow_pkg::A_FINISH) |-> pend_v_q)
    else $error("walk finished with no pending node");

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for depth_first_order_walker: edge loads, clears and walks
// predicted in SV and compared against every output transfer. Uses dfow_pkg.
module testbench;

  localparam int WatchdogLimit = 5000;
  localparam int SettleCycles  = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  dfow_pkg::in_item_t  in_item = '0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  dfow_pkg::out_item_t out_item_o;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_data = '0;

  dfow_pkg::in_item_t  pending_cmds[$];
  dfow_pkg::out_item_t visit_order_q[$];
  int          cmds_in_flight = 0;
  int          fault_count = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  logic [31:0] edge_rows [32];
  logic [5:0]  node_count_reg = '0;

  depth_first_order_walker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < 32; i++) edge_rows[i] = '0;
  end

  function automatic void predict_walk(input dfow_pkg::in_item_t it);
    logic [31:0] seen;
    logic [31:0] span;
    logic [31:0] cand;
    logic [4:0]  path [32];
    logic [4:0]  order [32];
    int          n;
    int          depth;
    int          produced;
    int          w;
    dfow_pkg::out_item_t r;
    case (it.mode)
      dfow_pkg::MODE_CLEAR: begin
        for (int i = 0; i < 32; i++) edge_rows[i] = '0;
      end
      dfow_pkg::MODE_ADD: begin
        edge_rows[it.src_node][it.dst_node] = 1'b1;
      end
      dfow_pkg::MODE_RUN: begin
        n = (node_count_reg > 6'd32) ? 32 : int'(node_count_reg);
        if (n == 0) begin
          r.node_index = '0;
          r.last = 1'b1;
          r.empty_res = 1'b1;
          visit_order_q.push_back(r);
        end else begin
          span = (n == 32) ? 32'hFFFF_FFFF : ((32'h1 << n) - 32'h1);
          seen = '0;
          produced = 0;
          for (int root = 0; root < n; root++) begin
            if (!seen[root]) begin
              seen[root] = 1'b1;
              order[produced] = root[4:0];
              produced++;
              path[0] = root[4:0];
              depth = 1;
              while (depth > 0) begin
                cand = edge_rows[path[depth-1]] & ~seen & span;
                if (cand != '0) begin
                  w = 0;
                  while (!cand[w]) w++;
                  seen[w] = 1'b1;
                  order[produced] = w[4:0];
                  produced++;
                  path[depth] = w[4:0];
                  depth++;
                end else begin
                  depth--;
                end
              end
            end
          end
          for (int i = 0; i < produced; i++) begin
            r.node_index = order[i];
            r.last = (i == produced - 1);
            r.empty_res = 1'b0;
            visit_order_q.push_back(r);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic push_cmd(input logic [1:0] mode, input logic [4:0] src, input logic [4:0] dst);
    dfow_pkg::in_item_t it;
    it.mode = mode;
    it.src_node = src;
    it.dst_node = dst;
    pending_cmds.push_back(it);
    cmds_in_flight++;
  endtask

  task automatic settle_and_write(input logic [5:0] value);
    while (cmds_in_flight != 0 || visit_order_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    node_count_reg = value;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else begin
      if (in_valid && in_ready_o) begin
        predict_walk(in_item);
        cmds_in_flight--;
      end
      if (!in_valid || in_ready_o) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item <= pending_cmds.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (visit_order_q.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: unexpected result node %0d last %0b empty %0b", $realtime,
                     out_item_o.node_index, out_item_o.last, out_item_o.empty_res);
        end else begin
          if (out_item_o.node_index !== visit_order_q[0].node_index ||
              out_item_o.last !== visit_order_q[0].last ||
              out_item_o.empty_res !== visit_order_q[0].empty_res) begin
            fault_count++;
            if (fault_count <= 10)
              $display("%0t: mismatch got node %0d last %0b empty %0b, exp node %0d last %0b empty %0b",
                       $realtime, out_item_o.node_index, out_item_o.last, out_item_o.empty_res,
                       visit_order_q[0].node_index, visit_order_q[0].last,
                       visit_order_q[0].empty_res);
          end
          void'(visit_order_q.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int walk_counts [8];
    int budget;
    int k;
    int lim;
    int a;
    int b;
    bit chain;
    walk_counts[0] = 32;
    walk_counts[1] = 7;
    walk_counts[2] = 0;
    walk_counts[3] = 63;
    walk_counts[4] = 1;
    walk_counts[5] = $urandom_range(2, 31);
    walk_counts[6] = 16;
    walk_counts[7] = 32;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // node count still at reset: empty walks, ignored mode, edge beyond the count
    push_cmd(dfow_pkg::MODE_RUN, 5'd0, 5'd0);
    push_cmd(dfow_pkg::MODE_NOP, 5'd31, 5'd31);
    push_cmd(dfow_pkg::MODE_CLEAR, 5'd31, 5'd0);
    push_cmd(dfow_pkg::MODE_ADD, 5'd31, 5'd31);
    push_cmd(dfow_pkg::MODE_RUN, 5'd31, 5'd31);

    settle_and_write(6'd5);
    push_cmd(dfow_pkg::MODE_ADD, 5'd0, 5'd3);
    push_cmd(dfow_pkg::MODE_ADD, 5'd0, 5'd1);
    push_cmd(dfow_pkg::MODE_ADD, 5'd1, 5'd2);
    push_cmd(dfow_pkg::MODE_ADD, 5'd2, 5'd0);
    push_cmd(dfow_pkg::MODE_ADD, 5'd3, 5'd4);
    push_cmd(dfow_pkg::MODE_ADD, 5'd4, 5'd31);
    push_cmd(dfow_pkg::MODE_ADD, 5'd31, 5'd1);
    push_cmd(dfow_pkg::MODE_RUN, 5'd0, 5'd0);
    push_cmd(dfow_pkg::MODE_NOP, 5'd0, 5'd0);
    push_cmd(dfow_pkg::MODE_RUN, 5'd17, 5'd10);

    settle_and_write(6'd32);
    push_cmd(dfow_pkg::MODE_ADD, 5'd31, 5'd0);
    push_cmd(dfow_pkg::MODE_ADD, 5'd0, 5'd31);
    push_cmd(dfow_pkg::MODE_ADD, 5'd30, 5'd31);
    push_cmd(dfow_pkg::MODE_RUN, 5'd0, 5'd0);
    push_cmd(dfow_pkg::MODE_CLEAR, 5'd0, 5'd0);
    push_cmd(dfow_pkg::MODE_RUN, 5'd0, 5'd0);

    settle_and_write(6'd63);
    push_cmd(dfow_pkg::MODE_ADD, 5'd5, 5'd6);
    push_cmd(dfow_pkg::MODE_RUN, 5'd0, 5'd0);

    settle_and_write(6'd1);
    push_cmd(dfow_pkg::MODE_RUN, 5'd0, 5'd0);

    for (int phase = 0; phase < 8; phase++) begin
      settle_and_write(walk_counts[phase][5:0]);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      lim = (walk_counts[phase] > 32) ? 32 : walk_counts[phase];
      budget = 0;
      while (budget < 22) begin
        if ($urandom_range(9) < 7) begin
          push_cmd(dfow_pkg::MODE_CLEAR, 5'($urandom_range(31)), 5'($urandom_range(31)));
          budget++;
        end
        k = $urandom_range(14);
        chain = ($urandom_range(9) < 3);
        for (int e = 0; e < k; e++) begin
          if ($urandom_range(19) == 0) begin
            push_cmd(dfow_pkg::MODE_NOP, 5'($urandom_range(31)), 5'($urandom_range(31)));
          end else begin
            if (lim > 0 && $urandom_range(9) < 8) begin
              a = $urandom_range(lim - 1);
              b = chain ? (a + 1) % lim : $urandom_range(lim - 1);
            end else begin
              a = $urandom_range(31);
              b = $urandom_range(31);
            end
            push_cmd(dfow_pkg::MODE_ADD, a[4:0], b[4:0]);
            budget++;
          end
        end
        push_cmd(dfow_pkg::MODE_RUN, 5'($urandom_range(31)), 5'($urandom_range(31)));
        budget++;
      end
    end

    while (cmds_in_flight != 0 || visit_order_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fault_count == 0 && visit_order_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
